>>> hw/rtl/sfla_pkg.sv
// Shared types, constants and helpers for the segregated free-list allocator.
// No dependencies; used by sfla_ram users and the top level.
package sfla_pkg;

   localparam int HEAP_CAPACITY   = 1024;
   localparam int BLOCKS_PER_SLAB = 8;
   localparam int HEADER_BYTES    = 16;
   localparam int NUM_CLASSES     = 4;
   localparam int MIN_CLASS_BYTES = 8;
   localparam int MAX_REQUEST     = 64;

   localparam int KIND_W   = 1;
   localparam int SIZE_W   = 10;
   localparam int ADDR_W   = 10;
   localparam int STATUS_W = 2;
   localparam int LIMIT_W  = 11;

   // Block pointer: a heap offset, with HEAP_CAPACITY itself as the null pointer.
   localparam int PTR_W      = $clog2(HEAP_CAPACITY + 1);
   localparam int CLS_W      = $clog2(NUM_CLASSES);
   localparam int LINK_DEPTH = HEAP_CAPACITY / MIN_CLASS_BYTES;
   localparam int LINK_IDX_W = $clog2(LINK_DEPTH);
   localparam int LINK_LSB   = $clog2(MIN_CLASS_BYTES);
   localparam int LINK_W     = CLS_W + PTR_W;

   localparam int SLAB_MAX = (MAX_REQUEST + HEADER_BYTES) * BLOCKS_PER_SLAB;
   localparam int SLAB_W   = $clog2(SLAB_MAX + 1);
   localparam int SUM_W    = ((SLAB_W > PTR_W) ? SLAB_W : PTR_W) + 1;
   localparam int CNT_W    = (BLOCKS_PER_SLAB > 1) ? $clog2(BLOCKS_PER_SLAB) : 1;

   localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(HEAP_CAPACITY);

   localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_MEM       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FREE_IGNORED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] block_address;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   address;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

   // Size class of a request: 8, 16, 32 or 64 bytes.
   function automatic logic [CLS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
      logic [CLS_W-1:0] c;
      c = CLS_W'(size > SIZE_W'(8)) + CLS_W'(size > SIZE_W'(16))
          + CLS_W'(size > SIZE_W'(32));
      return c;
   endfunction

   // Header plus user bytes of one block of a class.
   function automatic logic [PTR_W-1:0] block_bytes(input logic [CLS_W-1:0] cls);
      logic [PTR_W-1:0] b;
      b = PTR_W'(MIN_CLASS_BYTES) << cls;
      return b + PTR_W'(HEADER_BYTES);
   endfunction

   function automatic logic [SLAB_W-1:0] slab_bytes(input logic [CLS_W-1:0] cls);
      logic [SLAB_W-1:0] s;
      s = SLAB_W'(block_bytes(cls)) * SLAB_W'(BLOCKS_PER_SLAB);
      return s;
   endfunction

endpackage

>>> hw/rtl/sfla_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies. Read data holds while rd_en is low; a same-address read returns old data.
module sfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/segregated_free_list_allocator_top.sv
// Segregated free-list allocator: four size-class LIFO lists over a link memory.
// Depends on sfla_pkg and sfla_ram.
//
//   channel  | ports                          | direction | word
//   ---------+--------------------------------+-----------+----------------------
//   request  | req_valid req_ready req_word   | in        | kind, size, address
//   response | rsp_valid rsp_ready rsp_word   | out       | address, status
//   config   | psel penable pwrite paddr ...  | in/out    | heap_limit at 0x0
//
// An allocate hit or a free is accepted in S_IDLE (link read issued) and finished in
// S_EXEC, which uses the read data and writes back. An allocate that finds its list
// empty carves a slab in S_CARVE if the heap limit allows, one link-memory write per block.
// Rejected requests also finish in S_EXEC. One item is in flight at a time.
// Reset (synchronous) empties all lists and the heap; link memory is not cleared.
// A full response register stalls the finishing cycle until rsp_ready.
module segregated_free_list_allocator_top
   import sfla_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  req_word_type       req_word,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_word_type       rsp_word,

   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_CARVE = 2'd2;

   logic [1:0]         state_ff, state_in;
   req_word_type       item_ff, item_in;
   logic [CLS_W-1:0]   cls_ff, cls_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   carve_ptr_ff, carve_ptr_in;
   logic [CNT_W-1:0]   carve_cnt_ff, carve_cnt_in;
   logic [PTR_W-1:0]   heap_used_ff, heap_used_in;
   logic [LIMIT_W-1:0] heap_limit_ff;
   logic [PTR_W-1:0]   bin_head_ff [NUM_CLASSES];
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               req_accept;
   logic               out_free;
   logic [CLS_W-1:0]   req_class;
   logic [ADDR_W-1:0]  req_free_start;
   logic [CLS_W-1:0]   head_rd_sel;
   logic [PTR_W-1:0]   head_rd;
   logic               head_wr_en;
   logic [CLS_W-1:0]   head_wr_sel;
   logic [PTR_W-1:0]   head_wr_val;

   logic               ram_wr_en;
   logic [LINK_IDX_W-1:0] ram_wr_addr;
   logic [LINK_W-1:0]  ram_wr_data;
   logic [LINK_IDX_W-1:0] ram_rd_addr;
   logic [LINK_W-1:0]  ram_rd_data;
   logic [CLS_W-1:0]   link_rd_cls;
   logic [PTR_W-1:0]   link_rd_next;

   logic               too_large;
   logic               free_ignored;
   logic [ADDR_W-1:0]  free_start;
   logic [PTR_W-1:0]   limit_eff;
   logic [SUM_W-1:0]   slab_sum;
   logic [PTR_W-1:0]   blk;
   logic [PTR_W:0]     carve_next;
   logic [PTR_W:0]     first_next;
   logic               carve_last;
   logic               csr_write;

   // ---------------- handshake and decode ----------------
   assign req_accept = req_valid && req_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   assign req_class      = class_of(req_word.request_size);
   assign req_free_start = req_word.block_address - ADDR_W'(HEADER_BYTES);

   assign link_rd_cls  = ram_rd_data[LINK_W-1 -: CLS_W];
   assign link_rd_next = ram_rd_data[PTR_W-1:0];

   // single read port on the list heads: request class at accept, freed class after
   assign head_rd_sel = (state_ff == S_EXEC) ? link_rd_cls : req_class;
   assign head_rd     = bin_head_ff[head_rd_sel];

   assign too_large    = item_ff.request_size > SIZE_W'(MAX_REQUEST);
   assign free_ignored = item_ff.block_address < ADDR_W'(HEADER_BYTES);
   assign free_start   = item_ff.block_address - ADDR_W'(HEADER_BYTES);

   assign limit_eff  = (heap_limit_ff > LIMIT_W'(HEAP_CAPACITY)) ?
                       PTR_W'(HEAP_CAPACITY) : PTR_W'(heap_limit_ff);
   assign slab_sum   = SUM_W'(heap_used_ff) + SUM_W'(slab_bytes(cls_ff));
   assign blk        = block_bytes(cls_ff);
   assign carve_next = {1'b0, carve_ptr_ff} + {1'b0, blk};
   assign first_next = {1'b0, heap_used_ff} + {1'b0, blk};
   assign carve_last = (carve_cnt_ff == CNT_W'(BLOCKS_PER_SLAB - 1));

   assign ram_rd_addr = (req_word.kind == KIND_FREE) ?
                        req_free_start[LINK_LSB +: LINK_IDX_W] :
                        head_rd[LINK_LSB +: LINK_IDX_W];

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cls_in       = cls_ff;
      head_in      = head_ff;
      carve_ptr_in = carve_ptr_ff;
      carve_cnt_in = carve_cnt_ff;
      heap_used_in = heap_used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      head_wr_en   = 1'b0;
      head_wr_sel  = cls_ff;
      head_wr_val  = head_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = carve_ptr_ff[LINK_LSB +: LINK_IDX_W];
      ram_wr_data  = {cls_ff, carve_next[PTR_W-1:0]};

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               item_in  = req_word;
               cls_in   = req_class;
               head_in  = head_rd;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (item_ff.kind == KIND_ALLOC) begin
               if (too_large) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = '{address: '0, status: ST_TOO_LARGE};
                     state_in     = S_IDLE;
                  end
               end else if (head_ff == NIL_PTR) begin
                  if (slab_sum > SUM_W'(limit_eff)) begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = '{address: '0, status: ST_NO_MEM};
                        state_in     = S_IDLE;
                     end
                  end else begin
                     carve_ptr_in = heap_used_ff;
                     carve_cnt_in = '0;
                     state_in     = S_CARVE;
                  end
               end else if (out_free) begin
                  // pop: head moves to the link read at accept
                  head_wr_en   = 1'b1;
                  head_wr_val  = link_rd_next;
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '{address: ADDR_W'(head_ff + PTR_W'(HEADER_BYTES)),
                                   status: ST_OK};
                  state_in     = S_IDLE;
               end
            end else begin
               if (free_ignored) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = '{address: '0, status: ST_FREE_IGNORED};
                     state_in     = S_IDLE;
                  end
               end else if (out_free) begin
                  // push: keep the recorded class, link to the old head of that class
                  ram_wr_en    = 1'b1;
                  ram_wr_addr  = free_start[LINK_LSB +: LINK_IDX_W];
                  ram_wr_data  = {link_rd_cls, head_rd};
                  head_wr_en   = 1'b1;
                  head_wr_sel  = link_rd_cls;
                  head_wr_val  = PTR_W'(free_start);
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '{address: '0, status: ST_OK};
                  state_in     = S_IDLE;
               end
            end
         end

         S_CARVE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {cls_ff, carve_last ? NIL_PTR : carve_next[PTR_W-1:0]};
            if (!carve_last) begin
               carve_ptr_in = carve_next[PTR_W-1:0];
               carve_cnt_in = CNT_W'(carve_cnt_ff + 1'b1);
            end else if (out_free) begin
               // first block of the slab is handed out directly
               heap_used_in = slab_sum[PTR_W-1:0];
               head_wr_en   = 1'b1;
               head_wr_val  = (BLOCKS_PER_SLAB > 1) ? first_next[PTR_W-1:0] : NIL_PTR;
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{address: ADDR_W'(heap_used_ff + PTR_W'(HEADER_BYTES)),
                                status: ST_OK};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         heap_used_ff  <= '0;
         heap_limit_ff <= LIMIT_W'(1024);
         for (int i = 0; i < NUM_CLASSES; i++) begin
            bin_head_ff[i] <= NIL_PTR;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         heap_used_ff <= heap_used_in;
         if (csr_write) begin
            heap_limit_ff <= pwdata[LIMIT_W-1:0];
         end
         if (head_wr_en) begin
            bin_head_ff[head_wr_sel] <= head_wr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      cls_ff       <= cls_in;
      head_ff      <= head_in;
      carve_ptr_ff <= carve_ptr_in;
      carve_cnt_ff <= carve_cnt_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // ---------------- link memory: {class, next} per 8-byte slot ----------------
   sfla_ram #(
      .WIDTH (LINK_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------- register port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && !paddr[2];
   assign prdata    = paddr[2] ? 32'd0 : 32'(heap_limit_ff);

   // ---------------- checks ----------------
   a_heap_bounded: assert property (@(posedge clock) disable iff (reset)
      heap_used_ff <= PTR_W'(HEAP_CAPACITY))
      else $error("heap usage beyond capacity");

   a_carve_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CARVE |-> head_ff == NIL_PTR && item_ff.kind == KIND_ALLOC)
      else $error("slab carved for a non-empty list");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_EXEC)
      else $error("accepted word not executed next cycle");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ram_wr_en && !head_wr_en)
      else $error("state written while idle");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EXEC || $past(state_ff) == S_CARVE)
      else $error("response raised outside execution");

endmodule
